@@ rtl/vtp_pkg.sv @@
// Shared types and constants for the vertex transform and projection block.
`default_nettype none
package vtp_pkg;
  localparam int CENTRE_X    = 160;
  localparam int CENTRE_Y    = 120;
  localparam int LEFT_EDGE   = 1;
  localparam int RIGHT_EDGE  = 318;
  localparam int TOP_EDGE    = 1;
  localparam int BOTTOM_EDGE = 238;

  localparam int QDEPTH  = 4;
  localparam int QBITS   = 11;
  localparam int BSTAGES = QBITS + 2;

  typedef enum logic [2:0] {
    REG_X_ROW  = 3'd0,
    REG_Y_ROW  = 3'd1,
    REG_Z_ROW  = 3'd2,
    REG_TRANS  = 3'd3,
    REG_CAMERA = 3'd4,
    REG_FOCAL  = 3'd5,
    REG_PERSP  = 3'd6,
    REG_NONE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [47:0] x_row;
    logic [47:0] y_row;
    logic [47:0] z_row;
    logic [47:0] trans;
    logic [47:0] camera;
    logic [15:0] focal;
    logic        persp;
  } cfg_t;

  typedef struct packed {
    logic                    div;
    logic [2:0][15:0]        world;
    logic [1:0][16:0]        off;
    logic [15:0]             offz;
  } qword_t;
endpackage
`default_nettype wire

@@ rtl/vertex_transform_project.sv @@
// Vertex transform and projection top level with register file.
// Pipeline: 19 register stages (4 front, one queue write, BSTAGES+1 = 14 back).
// Throughput: one vertex per cycle while neither out_ready nor a full queue stalls;
// the back divider does one restoring step in each of its last QBITS stages. Reset
// clears all pipeline valids and the queue, and loads the register defaults
// (identity matrix, camera at z = -100, focal 110, perspective).
`default_nettype none
module vertex_transform_project import vtp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] local_x,
  input  wire logic [15:0] local_y,
  input  wire logic [15:0] local_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      world_x,
  output logic [15:0]      world_y,
  output logic [15:0]      world_z,
  output logic [9:0]       screen_x,
  output logic [9:0]       screen_y,
  output logic             divided_by_depth
);
  cfg_t     cfg;
  reg_idx_t idx;
  logic     push, full, empty, pop;
  qword_t   wword, rword;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_row  <= 48'h0000_0000_1000;
      cfg.y_row  <= 48'h0000_1000_0000;
      cfg.z_row  <= 48'h1000_0000_0000;
      cfg.trans  <= '0;
      cfg.camera <= 48'hF9C0_0000_0000;
      cfg.focal  <= 16'd1760;
      cfg.persp  <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_X_ROW:  cfg.x_row  <= pwdata[47:0];
        REG_Y_ROW:  cfg.y_row  <= pwdata[47:0];
        REG_Z_ROW:  cfg.z_row  <= pwdata[47:0];
        REG_TRANS:  cfg.trans  <= pwdata[47:0];
        REG_CAMERA: cfg.camera <= pwdata[47:0];
        REG_FOCAL:  cfg.focal  <= pwdata[15:0];
        REG_PERSP:  cfg.persp  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_ROW:  prdata = 64'(cfg.x_row);
      REG_Y_ROW:  prdata = 64'(cfg.y_row);
      REG_Z_ROW:  prdata = 64'(cfg.z_row);
      REG_TRANS:  prdata = 64'(cfg.trans);
      REG_CAMERA: prdata = 64'(cfg.camera);
      REG_FOCAL:  prdata = 64'(cfg.focal);
      REG_PERSP:  prdata = 64'(cfg.persp);
      default:    prdata = '0;
    endcase
  end

  vtp_front u_front (
    .clk, .rst, .cfg,
    .valid (in_valid), .ready (in_ready),
    .local_x, .local_y, .local_z,
    .push, .full, .qword (wword)
  );

  vtp_fifo u_fifo (
    .clk, .rst, .push, .wdata (wword), .full,
    .pop, .empty, .rdata (rword)
  );

  vtp_back u_back (
    .clk, .rst, .focal (cfg.focal),
    .empty, .pop, .qword (rword),
    .valid (out_valid), .ready (out_ready),
    .world_x, .world_y, .world_z, .screen_x, .screen_y, .divided_by_depth
  );
endmodule
`default_nettype wire

@@ rtl/vtp_front.sv @@
// Front pipeline: matrix multiply, translate, round, saturate, camera offset.
`default_nettype none
module vtp_front import vtp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfg_t         cfg,
  input  wire logic         valid,
  output logic              ready,
  input  wire logic [15:0]  local_x,
  input  wire logic [15:0]  local_y,
  input  wire logic [15:0]  local_z,
  output logic              push,
  input  wire logic         full,
  output qword_t            qword
);
  logic                           a_valid, b_valid, c_valid, d_valid;
  logic signed [2:0][15:0]        a_loc;
  logic signed [2:0][2:0][31:0]   b_prod;
  logic signed [2:0][15:0]        c_world;
  qword_t                         d_word;
  logic                           en;
  logic signed [34:0]             sum [3];
  logic signed [34:0]             flr [3];
  logic signed [16:0]             offv [3];

  assign en    = !(d_valid && full);
  assign ready = en;
  assign push  = d_valid && en;
  assign qword = d_word;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a] = 35'($signed(b_prod[a][0])) + 35'($signed(b_prod[a][1]))
             + 35'($signed(b_prod[a][2]))
             + (35'($signed(cfg.trans[16*a +: 16])) <<< 12) + 35'sd2048;
      flr[a] = sum[a] >>> 12;
      offv[a] = 17'($signed(c_world[a])) - 17'($signed(cfg.camera[16*a +: 16]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      a_valid <= valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_loc[0] <= local_x;
      a_loc[1] <= local_y;
      a_loc[2] <= local_z;
      for (int a = 0; a < 3; a++) begin
        b_prod[a][0] <= $signed(a_loc[0]) * $signed(cfg.x_row[16*a +: 16]);
        b_prod[a][1] <= $signed(a_loc[1]) * $signed(cfg.y_row[16*a +: 16]);
        b_prod[a][2] <= $signed(a_loc[2]) * $signed(cfg.z_row[16*a +: 16]);
        if (flr[a] > 35'sd32767) begin
          c_world[a] <= 16'sh7fff;
        end else if (flr[a] < -35'sd32768) begin
          c_world[a] <= 16'sh8000;
        end else begin
          c_world[a] <= flr[a][15:0];
        end
        d_word.world[a] <= c_world[a];
      end
      d_word.off[0] <= offv[0];
      d_word.off[1] <= offv[1];
      d_word.offz   <= offv[2][15:0];
      d_word.div    <= cfg.persp && !offv[2][16] && (offv[2] != 17'sd0);
    end
  end
endmodule
`default_nettype wire

@@ rtl/vtp_fifo.sv @@
// Short queue between the transform front and the projection back.
`default_nettype none
module vtp_fifo import vtp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire qword_t wdata,
  output logic        full,
  input  wire logic   pop,
  output logic        empty,
  output qword_t      rdata
);
  localparam int AW = $clog2(QDEPTH);
  qword_t           mem [QDEPTH];
  logic [AW-1:0]    wp, rp;
  logic [AW:0]      cnt;
  logic             do_pop;

  assign full   = (cnt == (AW+1)'(QDEPTH));
  assign empty  = (cnt == '0);
  assign rdata  = mem[rp];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end
endmodule
`default_nettype wire

@@ rtl/vtp_back.sv @@
// Back: perspective divide by restoring steps or ortho shift, centre, clamp, output.
`default_nettype none
module vtp_back import vtp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] focal,
  input  wire logic        empty,
  output logic             pop,
  input  wire qword_t      qword,
  output logic             valid,
  input  wire logic        ready,
  output logic [15:0]      world_x,
  output logic [15:0]      world_y,
  output logic [15:0]      world_z,
  output logic [9:0]       screen_x,
  output logic [9:0]       screen_y,
  output logic             divided_by_depth
);
  typedef struct packed {
    logic                    div;
    logic [2:0][15:0]        world;
    logic [1:0][12:0]        ortho;
    logic [19:0]             den;
    logic [1:0][33:0]        num;
    logic [1:0]              neg;
    logic [1:0]              ovf;
    logic [1:0][QBITS-1:0]   quo;
  } bst_t;

  bst_t               st  [BSTAGES];
  bst_t               nst [BSTAGES];
  logic [BSTAGES-1:0] sv;
  logic               en;
  logic               o_valid;
  logic [2:0][15:0]   o_world;
  logic [1:0][9:0]    o_scr;
  logic               o_div;
  logic [33:0]        mag [2];
  logic [33:0]        dsh [BSTAGES-2];
  logic [13:0]        qm  [2];
  logic signed [13:0] q   [2];
  logic signed [14:0] pix [2];
  logic [1:0][9:0]    clp;

  assign en    = !(o_valid && !ready);
  assign pop   = en && !empty;
  assign valid = o_valid;
  assign world_x = o_world[0];
  assign world_y = o_world[1];
  assign world_z = o_world[2];
  assign screen_x = o_scr[0];
  assign screen_y = o_scr[1];
  assign divided_by_depth = o_div;

  always_comb begin
    nst[0].div   = qword.div;
    nst[0].world = qword.world;
    nst[0].den   = {qword.offz, 4'b0};
    nst[0].neg   = '0;
    nst[0].ovf   = '0;
    nst[0].quo   = '0;
    for (int a = 0; a < 2; a++) begin
      nst[0].ortho[a] = qword.off[a][16:4];
      nst[0].num[a]   = $signed({1'b0, focal}) * $signed(qword.off[a]);
    end
    nst[1] = st[0];
    for (int a = 0; a < 2; a++) begin
      mag[a] = st[0].num[a][33] ? 34'(-$signed(st[0].num[a])) : st[0].num[a];
      nst[1].neg[a] = st[0].num[a][33];
      nst[1].num[a] = mag[a];
      nst[1].ovf[a] = mag[a] >= (34'(st[0].den) << QBITS);
    end
    for (int j = 0; j < BSTAGES-2; j++) begin
      dsh[j] = 34'(st[j+1].den) << (QBITS-1-j);
      nst[j+2] = st[j+1];
      for (int a = 0; a < 2; a++) begin
        if (st[j+1].num[a] >= dsh[j]) begin
          nst[j+2].num[a] = st[j+1].num[a] - dsh[j];
          nst[j+2].quo[a][QBITS-1-j] = 1'b1;
        end
      end
    end
    for (int a = 0; a < 2; a++) begin
      qm[a] = 14'(st[BSTAGES-1].quo[a]) + 14'(st[BSTAGES-1].num[a] != '0);
      if (!st[BSTAGES-1].div) begin
        q[a] = 14'($signed(st[BSTAGES-1].ortho[a]));
      end else if (st[BSTAGES-1].ovf[a]) begin
        q[a] = st[BSTAGES-1].neg[a] ? -14'sd4096 : 14'sd4096;
      end else begin
        q[a] = st[BSTAGES-1].neg[a] ? -$signed(qm[a])
                                    : $signed(14'(st[BSTAGES-1].quo[a]));
      end
    end
    pix[0] = 15'(q[0]) + 15'(CENTRE_X);
    pix[1] = 15'(q[1]) + 15'(CENTRE_Y);
    if (pix[0] > 15'(RIGHT_EDGE))      clp[0] = 10'(RIGHT_EDGE);
    else if (pix[0] < 15'(LEFT_EDGE))  clp[0] = 10'(LEFT_EDGE);
    else                               clp[0] = pix[0][9:0];
    if (pix[1] > 15'(BOTTOM_EDGE))     clp[1] = 10'(BOTTOM_EDGE);
    else if (pix[1] < 15'(TOP_EDGE))   clp[1] = 10'(TOP_EDGE);
    else                               clp[1] = pix[1][9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv      <= '0;
      o_valid <= 1'b0;
    end else if (en) begin
      sv      <= {sv[BSTAGES-2:0], !empty};
      o_valid <= sv[BSTAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < BSTAGES; i++) begin
        st[i] <= nst[i];
      end
      o_world <= st[BSTAGES-1].world;
      o_scr   <= clp;
      o_div   <= st[BSTAGES-1].div;
    end
  end
endmodule
`default_nettype wire
